FILE: hdl/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
// Used by the core, the port checker and the testbench; depends on nothing.
package mts_pkg;

   localparam int DATA_W        = 32;
   localparam int OCC_W         = 9;
   localparam int STAT_W        = 2;
   localparam int DEF_DEPTH     = 256;
   localparam int RSP_TDATA_W   = 80;   // top, min, occupancy, padded to bytes
   localparam int RSP_TUSER_W   = 3;    // is_empty, status
   localparam int RSP_PAD_W     = RSP_TDATA_W - 2 * DATA_W - OCC_W;

   localparam logic signed [DATA_W-1:0] MIN_RESET = 32'sh7FFF_FFFF;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } state_type;

endpackage

FILE: hdl/mts_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the stack entries for the min-tracking stack.
module mts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/min_tracking_stack_core.sv
// Min-tracking stack: bounded LIFO of signed 32-bit values reporting its minimum.
// Depends on mts_pkg and mts_ram.
//
// Usage
//   req channel : one beat per operation. req_tuser = command (0 push, 1 pop),
//                 req_tdata = value to push (ignored on pop).
//   rsp channel : one beat per request, in order: top entry, minimum entry,
//                 occupancy, empty flag and status (0 ok, 1 pop on empty
//                 ignored, 2 push on full ignored). Top and minimum read zero
//                 when the stack is empty.
//   Each RAM word keeps the pushed value beside the running minimum of all
//   entries up to and including it, so a pop never rescans the stack.
//   Pace: a push, an ignored operation or a pop down to empty is done in
//   ST_IDLE; a pop that leaves entries also passes through ST_POP, as the new
//   top and its running minimum come back from the RAM's registered read.
//   Response: the beat is valid the cycle after the request is accepted
//   (after ST_POP for a pop that reads the RAM).
//   Stalls: one response register. A new request is taken in ST_IDLE while
//   the response register is empty or its beat is taken in the same cycle,
//   so rsp_tready low holds the stack after at most one waiting beat.
//   Reset: empty stack, minimum back to the most positive value, no response
//   pending. The RAM is not cleared; only entries below the count are read.
module min_tracking_stack_core #(
   parameter int STACK_DEPTH = mts_pkg::DEF_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [mts_pkg::DATA_W-1:0]       req_tdata,  // [31:0] value
   input  logic                             req_tuser,  // [0] command
   // response
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [mts_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [31:0] top_value,
                                                       // [63:32] min_value,
                                                       // [72:64] occupancy, zero pad
   output logic [mts_pkg::RSP_TUSER_W-1:0]  rsp_tuser   // [0] is_empty, [2:1] status
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int DW     = mts_pkg::DATA_W;
   localparam int MEM_W  = 2 * DW;

   // control state
   mts_pkg::state_type  state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // running top and minimum of the stack
   logic signed [DW-1:0] top_ff, top_in;
   logic signed [DW-1:0] min_ff, min_in;

   // response register
   logic signed [DW-1:0]             rsp_top_ff, rsp_top_in;
   logic signed [DW-1:0]             rsp_min_ff, rsp_min_in;
   logic [mts_pkg::OCC_W-1:0]        rsp_occ_ff, rsp_occ_in;
   logic                             rsp_empty_ff, rsp_empty_in;
   logic [mts_pkg::STAT_W-1:0]       rsp_status_ff, rsp_status_in;

   // RAM port
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [MEM_W-1:0]  ram_wdata, ram_rdata;

   logic                 take;
   logic                 full;
   logic signed [DW-1:0] push_val;
   logic signed [DW-1:0] push_min;

   assign req_tready = (state_ff == mts_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign take       = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(STACK_DEPTH));
   assign push_val   = $signed(req_tdata);
   assign push_min   = ((count_ff == '0) || (push_val < min_ff)) ? push_val : min_ff;

   mts_ram #(
      .WIDTH (MEM_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      top_in        = top_ff;
      min_in        = min_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_top_in    = rsp_top_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_re        = 1'b0;
      ram_waddr     = count_ff[ADDR_W-1:0];
      ram_wdata     = {push_min, push_val};
      ram_raddr     = ADDR_W'(count_ff - CNT_W'(2));

      case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (take) begin
               rsp_valid_in = 1'b1;
               if (req_tuser == mts_pkg::CMD_PUSH) begin
                  if (full) begin
                     // ignored: report the unchanged stack
                     rsp_top_in    = top_ff;
                     rsp_min_in    = min_ff;
                     rsp_occ_in    = mts_pkg::OCC_W'(count_ff);
                     rsp_empty_in  = 1'b0;
                     rsp_status_in = mts_pkg::STAT_PUSH_FULL;
                  end else begin
                     ram_we        = 1'b1;
                     count_in      = count_ff + CNT_W'(1);
                     top_in        = push_val;
                     min_in        = push_min;
                     rsp_top_in    = push_val;
                     rsp_min_in    = push_min;
                     rsp_occ_in    = mts_pkg::OCC_W'(count_in);
                     rsp_empty_in  = 1'b0;
                     rsp_status_in = mts_pkg::STAT_OK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_top_in    = '0;
                     rsp_min_in    = '0;
                     rsp_occ_in    = '0;
                     rsp_empty_in  = 1'b1;
                     rsp_status_in = mts_pkg::STAT_POP_EMPTY;
                  end else if (count_ff == CNT_W'(1)) begin
                     count_in      = '0;
                     top_in        = '0;
                     min_in        = mts_pkg::MIN_RESET;
                     rsp_top_in    = '0;
                     rsp_min_in    = '0;
                     rsp_occ_in    = '0;
                     rsp_empty_in  = 1'b1;
                     rsp_status_in = mts_pkg::STAT_OK;
                  end else begin
                     // new top sits one below; its word arrives next cycle
                     rsp_valid_in = 1'b0;
                     ram_re       = 1'b1;
                     count_in     = count_ff - CNT_W'(1);
                     state_in     = mts_pkg::ST_POP;
                  end
               end
            end
         end
         mts_pkg::ST_POP: begin
            top_in        = $signed(ram_rdata[DW-1:0]);
            min_in        = $signed(ram_rdata[MEM_W-1:DW]);
            rsp_valid_in  = 1'b1;
            rsp_top_in    = top_in;
            rsp_min_in    = min_in;
            rsp_occ_in    = mts_pkg::OCC_W'(count_ff);
            rsp_empty_in  = 1'b0;
            rsp_status_in = mts_pkg::STAT_OK;
            state_in      = mts_pkg::ST_IDLE;
         end
         default: begin
            state_in = mts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mts_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         top_ff       <= '0;
         min_ff       <= mts_pkg::MIN_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         top_ff       <= top_in;
         min_ff       <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_top_ff    <= rsp_top_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{mts_pkg::RSP_PAD_W{1'b0}}, rsp_occ_ff, rsp_min_ff, rsp_top_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_empty_ff};

endmodule

FILE: hdl/mts_checker.sv
// Port-level checks for the min-tracking stack, bound to the core.
// Depends on mts_pkg and min_tracking_stack_core.
module mts_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [mts_pkg::DATA_W-1:0]       req_tdata,
   input logic                             req_tuser,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [mts_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input logic [mts_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);

   // empty flag agrees with occupancy
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (rsp_tdata[72:64] == '0)))
      else $error("empty flag disagrees with occupancy");

   // empty stack reports zero top and minimum
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[63:0] == '0))
      else $error("empty stack reports non-zero top or minimum");

   // minimum never above the top entry
   a_min_le_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |->
         ($signed(rsp_tdata[63:32]) <= $signed(rsp_tdata[31:0])))
      else $error("minimum above top entry");

   // held response beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("response beat changed while stalled");

   // no response straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind min_tracking_stack_core mts_checker u_mts_checker (.*);

FILE: tb/sv/mts_stack_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the min-tracking stack: mirrors the stack from accepted request
// beats and compares each response beat with the oldest prediction.
// Depends on mts_pkg.
module mts_stack_checker #(
   parameter int STACK_DEPTH = mts_pkg::DEF_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [mts_pkg::DATA_W-1:0]       req_tdata,  // [31:0] value
   input  logic                             req_tuser,  // [0] command
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [mts_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // [31:0] top, [63:32] min,
                                                       // [72:64] occupancy, zero pad
   input  logic [mts_pkg::RSP_TUSER_W-1:0]  rsp_tuser,  // [0] is_empty, [2:1] status
   output int                               mismatch_count,
   output int                               pending_count
);
   import mts_pkg::*;

   typedef struct {
      logic signed [DATA_W-1:0] top_value;
      logic signed [DATA_W-1:0] min_value;
      logic [OCC_W-1:0]         occupancy;
      logic                     is_empty;
      logic [STAT_W-1:0]        status;
   } stack_view_type;

   logic signed [DATA_W-1:0] shadow_entries [STACK_DEPTH];
   int                       shadow_fill;
   logic signed [DATA_W-1:0] shadow_min;
   stack_view_type           view_expect_q [$];

   // apply one operation to the shadow stack, return what the block should report
   function automatic stack_view_type apply_stack_op(input logic cmd,
                                                     input logic signed [DATA_W-1:0] val);
      stack_view_type           v;
      logic signed [DATA_W-1:0] popped;
      v.status = STAT_OK;
      if (cmd == CMD_PUSH) begin
         if (shadow_fill >= STACK_DEPTH) begin
            v.status = STAT_PUSH_FULL;
         end else begin
            if (shadow_fill == 0 || val < shadow_min) shadow_min = val;
            shadow_entries[shadow_fill] = val;
            shadow_fill++;
         end
      end else begin
         if (shadow_fill == 0) begin
            v.status = STAT_POP_EMPTY;
         end else begin
            popped = shadow_entries[shadow_fill-1];
            shadow_fill--;
            if (shadow_fill == 0) begin
               shadow_min = MIN_RESET;
            end else if (popped == shadow_min) begin
               // minimum left the stack: rescan what remains
               shadow_min = shadow_entries[0];
               for (int i = 1; i < shadow_fill; i++) begin
                  if (shadow_entries[i] < shadow_min) shadow_min = shadow_entries[i];
               end
            end
         end
      end
      if (shadow_fill == 0) begin
         v.top_value = '0;
         v.min_value = '0;
         v.is_empty  = 1'b1;
      end else begin
         v.top_value = shadow_entries[shadow_fill-1];
         v.min_value = shadow_min;
         v.is_empty  = 1'b0;
      end
      v.occupancy = OCC_W'(shadow_fill);
      return v;
   endfunction

   task automatic compare_field(input string name, input logic [DATA_W-1:0] exp_v,
                                input logic [DATA_W-1:0] got_v);
      if (exp_v !== got_v) begin
         $error("%s: expected 'h%0h, got 'h%0h", name, exp_v, got_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      stack_view_type want;
      stack_view_type fresh;
      if (reset) begin
         shadow_fill    = 0;
         shadow_min     = MIN_RESET;
         mismatch_count = 0;
         view_expect_q.delete();
      end else begin
         // response first: a request taken on this edge cannot answer on it
         if (rsp_tvalid && rsp_tready) begin
            if (view_expect_q.size() == 0) begin
               $error("response beat with no request outstanding");
               mismatch_count++;
            end else begin
               want = view_expect_q.pop_front();
               compare_field("top_value", want.top_value, rsp_tdata[31:0]);
               compare_field("min_value", want.min_value, rsp_tdata[63:32]);
               compare_field("occupancy", DATA_W'(want.occupancy), DATA_W'(rsp_tdata[72:64]));
               compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(rsp_tuser[0]));
               compare_field("status", DATA_W'(want.status), DATA_W'(rsp_tuser[2:1]));
            end
         end
         if (req_tvalid && req_tready) begin
            fresh         = apply_stack_op(req_tuser, req_tdata);
            view_expect_q = {view_expect_q, fresh};
         end
      end
      pending_count = view_expect_q.size();
   end

endmodule

FILE: tb/sv/tb_min_tracking_stack_core.sv
`timescale 1ns / 100ps
// Top of the min-tracking stack testbench: clock, reset, request stimulus and verdict.
// Depends on mts_pkg, min_tracking_stack_core and mts_stack_checker.
module tb_min_tracking_stack_core;
   import mts_pkg::*;

   // Watchdog limit, far above the length of the slowest plausible run.
   localparam int CYCLE_LIMIT = 200_000;
   localparam int SEG_COUNT   = 10;
   localparam int SEG_BEATS   = 40;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [DATA_W-1:0]      req_tdata;   // [31:0] value
   logic                   req_tuser;   // [0] command
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;   // [31:0] top, [63:32] min, [72:64] occupancy
   logic [RSP_TUSER_W-1:0] rsp_tuser;   // [0] is_empty, [2:1] status

   int   mismatch_count;
   int   pending_count;
   int   cycle_count = 0;
   logic steady = 1'b0;   // high: neither side idles

   min_tracking_stack_core #(
      .STACK_DEPTH (DEF_DEPTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Scoreboard sits beside the core and only watches its ports.
   mts_stack_checker #(
      .STACK_DEPTH (DEF_DEPTH)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver back-pressure: refuses about 37 beats in 100 outside the steady stretch.
   // Driven on the falling edge so the core sees a settled value at the rising edge.
   always @(negedge clock) begin
      rsp_tready = steady || ($urandom_range(99) >= 37);
   end

   // Value mix: extremes, a narrow band near zero so that equal minima stack up
   // (pop of a duplicated minimum), and full-range values for bit toggling.
   function automatic logic [DATA_W-1:0] pick_value();
      int band;
      case ($urandom_range(9))
         0: pick_value = 32'h8000_0000;
         1: pick_value = 32'h7FFF_FFFF;
         2, 3, 4: begin
            band       = int'($urandom_range(12)) - 6;
            pick_value = DATA_W'(band);
         end
         default: pick_value = $urandom;
      endcase
   endfunction

   // One request beat. Called at a falling edge; returns at the falling edge
   // after the beat was taken, with tvalid still high so that back-to-back
   // beats need no drop in between.
   task automatic issue_op(input logic cmd, input logic [DATA_W-1:0] val);
      while (!steady && $urandom_range(99) < 37) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Hold the sender until every predicted response has been seen.
   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int pop_pct;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_PUSH;
      req_tdata  = '0;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // --- directed: empty pops, extremes, duplicated minimum, rescan, pop to empty
      issue_op(CMD_POP,  32'h0000_0000);   // pop on empty
      issue_op(CMD_PUSH, 32'h0000_0000);   // first push sets the minimum
      issue_op(CMD_PUSH, 32'h7FFF_FFFF);
      issue_op(CMD_PUSH, 32'h8000_0000);
      issue_op(CMD_PUSH, 32'hFFFF_FFFF);
      issue_op(CMD_PUSH, 32'h0000_0001);
      issue_op(CMD_PUSH, 32'h8000_0000);   // minimum held twice
      issue_op(CMD_POP,  32'hFFFF_FFFF);   // one copy leaves, minimum stays
      issue_op(CMD_POP,  32'h1234_5678);
      issue_op(CMD_POP,  32'h0000_0000);
      issue_op(CMD_POP,  32'h0000_0000);   // last copy of minimum leaves: rescan
      issue_op(CMD_POP,  32'h0000_0000);
      issue_op(CMD_POP,  32'h0000_0000);   // pop to empty
      issue_op(CMD_POP,  32'h0000_0000);   // pop on empty again
      issue_op(CMD_PUSH, 32'h5555_5555);
      issue_op(CMD_PUSH, 32'hAAAA_AAAA);
      issue_op(CMD_POP,  32'h5555_5555);
      issue_op(CMD_POP,  32'hAAAA_AAAA);
      issue_op(CMD_POP,  32'hFFFF_FFFF);
      wait_drained();

      // --- fill to full and push past it: push on full, occupancy at its top bit
      repeat (DEF_DEPTH + 3) issue_op(CMD_PUSH, pick_value());

      // --- random segments, each with its own pop bias; the first is biased to pop
      for (int seg = 0; seg < SEG_COUNT; seg++) begin
         case ($urandom_range(2))
            0:       pop_pct = 20;
            1:       pop_pct = 50;
            default: pop_pct = 80;
         endcase
         if (seg == 0) pop_pct = 85;
         steady = (seg == 3);           // one segment with no idling at all
         if (seg == 6) wait_drained();
         repeat (SEG_BEATS) begin
            issue_op(($urandom_range(99) < pop_pct) ? CMD_POP : CMD_PUSH, pick_value());
         end
      end
      steady = 1'b0;

      // --- tail: drain, then wait out a margin before the verdict
      wait_drained();
      repeat (8) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
